@@ hdl/gpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gpfs_pkg
// Shared types and constants for the greatest prime factor sieve table.
// ----------------------------------------------------------------------------
package gpfs_pkg;

    localparam int GPFS_TABLE_DEPTH = 65536;

    // Field and counter widths fixed by the 16-bit index and limit
    localparam int FACTOR_W  = 16;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 17;   // holds limit + 1
    localparam int STATUS_W  = 2;
    localparam int PRIME_W   = 9;    // sieving primes never pass 257
    localparam int SQ_W      = 17;   // p * p for those primes
    localparam int REM_W     = 9;
    localparam int DIVCNT_W  = 4;    // one quotient bit per cycle, 16 bits

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_QUERY_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BUILD_DONE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_PRIME,
        S_PRIME_CHK,
        S_MULT,
        S_MULT_LD,
        S_CHECK,
        S_DIV,
        S_DIV_END,
        S_DONE
    } gpfs_state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_QUERY,
        RD_PRIME,
        RD_MULT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INIT,
        WR_MULT
    } wr_sel_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    load_query;
        logic    load_build;
        logic    start_build;
        logic    init_adv;
        logic    sieve_start;
        logic    prime_adv;
        logic    mult_start;
        logic    mult_adv;
        logic    v_load;
        logic    v_quot;
        logic    div_start;
        logic    div_step;
        logic    commit_built;
    } gpfs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic build_skip;
        logic init_last;
        logic prime_go;
        logic prime_hit;
        logic mult_go;
        logic v_gt_p;
        logic div_last;
        logic div_exact;
    } gpfs_sts_t;

endpackage

@@ hdl/gpfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpfs_ctrl
// Sequencer: input handshake, build passes and per-multiple division loop.
// ----------------------------------------------------------------------------
module gpfs_ctrl
    import gpfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      command,
    output logic      in_ready,
    input  gpfs_sts_t sts,
    output gpfs_cmd_t cmd
);

    gpfs_state_t state_reg;
    gpfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    if (command == CMD_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        cmd.rd_sel     = RD_QUERY;
                    end
                    else if (sts.build_skip)
                    begin
                        cmd.load_build = 1'b1;
                    end
                    else
                    begin
                        cmd.start_build = 1'b1;
                        state_next      = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.wr_sel = WR_INIT;
                if (sts.init_last)
                begin
                    cmd.sieve_start = 1'b1;
                    state_next      = S_PRIME;
                end
                else
                begin
                    cmd.init_adv = 1'b1;
                end
            end
            S_PRIME:
            begin
                if (sts.prime_go)
                begin
                    cmd.rd_sel = RD_PRIME;
                    state_next = S_PRIME_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PRIME_CHK:
            begin
                if (sts.prime_hit)
                begin
                    cmd.mult_start = 1'b1;
                    state_next     = S_MULT;
                end
                else
                begin
                    cmd.prime_adv = 1'b1;
                    state_next    = S_PRIME;
                end
            end
            S_MULT:
            begin
                if (sts.mult_go)
                begin
                    cmd.rd_sel = RD_MULT;
                    state_next = S_MULT_LD;
                end
                else
                begin
                    cmd.prime_adv = 1'b1;
                    state_next    = S_PRIME;
                end
            end
            S_MULT_LD:
            begin
                cmd.v_load = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.v_gt_p)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.wr_sel   = WR_MULT;
                    cmd.mult_adv = 1'b1;
                    state_next   = S_MULT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                if (sts.div_exact)
                begin
                    cmd.v_quot = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.wr_sel   = WR_MULT;
                    cmd.mult_adv = 1'b1;
                    state_next   = S_MULT;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_build   = 1'b1;
                    cmd.commit_built = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/gpfs_dp.sv @@
// ----------------------------------------------------------------------------
// gpfs_dp
// Table memory, sieve counters, serial divider and result register.
// ----------------------------------------------------------------------------
module gpfs_dp
    import gpfs_pkg::*;
#(
    parameter int TABLE_DEPTH = GPFS_TABLE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    input  logic [LIMIT_W-1:0]   index,
    input  gpfs_cmd_t            cmd,
    output gpfs_sts_t            sts,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FACTOR_W-1:0]  factor,
    output logic [STATUS_W-1:0]  status
);

    // Limits never pass 65535, so deeper storage would go unused
    localparam int MEM_DEPTH = (TABLE_DEPTH > 65536) ? 65536 : TABLE_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] MAX_LIM = COUNT_W'(MEM_DEPTH - 1);

    logic [FACTOR_W-1:0] mem [MEM_DEPTH];

    logic [LIMIT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]  built_reg;
    logic [LIMIT_W-1:0]  lim_reg;
    logic [PRIME_W-1:0]  p_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [COUNT_W-1:0]  i_reg;
    logic [FACTOR_W-1:0] v_reg;
    logic [FACTOR_W-1:0] quo_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [DIVCNT_W-1:0] div_cnt_reg;
    logic [FACTOR_W-1:0] rdata_reg;
    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [LIMIT_W-1:0]  eff_lim;
    logic                in_range;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [FACTOR_W-1:0] wr_data;
    logic [REM_W:0]      trial;
    logic                trial_ge;
    logic [REM_W-1:0]    rem_next;
    logic [COUNT_W-1:0]  lim_ext;

    assign eff_lim  = ({1'b0, limit_reg} > MAX_LIM) ? LIMIT_W'(MAX_LIM) : limit_reg;
    assign in_range = {1'b0, index} < built_reg;
    assign lim_ext  = {1'b0, lim_reg};

    // Memory port selection
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = AW'(i_reg);
        unique case (cmd.rd_sel)
            RD_QUERY: rd_addr = AW'(index);
            RD_PRIME: rd_addr = AW'(p_reg);
            RD_MULT:  rd_addr = AW'(i_reg);
            default:  rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = AW'(i_reg);
        wr_data = v_reg;
        unique case (cmd.wr_sel)
            WR_INIT: wr_data = i_reg[FACTOR_W-1:0];
            WR_MULT: wr_data = v_reg;
            default: wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[FACTOR_W-1]};
    assign trial_ge = trial >= {1'b0, p_reg};
    assign rem_next = trial_ge ? REM_W'(trial - {1'b0, p_reg}) : trial[REM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start_build)
        begin
            lim_reg <= eff_lim;
        end

        if (cmd.start_build)
        begin
            i_reg <= '0;
        end
        else if (cmd.init_adv)
        begin
            i_reg <= i_reg + COUNT_W'(1);
        end
        else if (cmd.mult_start)
        begin
            i_reg <= COUNT_W'({p_reg, 1'b0});
        end
        else if (cmd.mult_adv)
        begin
            i_reg <= i_reg + COUNT_W'(p_reg);
        end

        if (cmd.sieve_start)
        begin
            p_reg  <= PRIME_W'(2);
            sq_reg <= SQ_W'(4);
        end
        else if (cmd.prime_adv)
        begin
            p_reg  <= p_reg + PRIME_W'(1);
            sq_reg <= sq_reg + SQ_W'({p_reg, 1'b1});
        end

        if (cmd.v_load)
        begin
            v_reg <= rdata_reg;
        end
        else if (cmd.v_quot)
        begin
            v_reg <= quo_reg;
        end

        if (cmd.div_start)
        begin
            quo_reg     <= v_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[FACTOR_W-2:0], trial_ge};
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIVCNT_W'(1);
        end

        if (cmd.load_query)
        begin
            out_ok_reg     <= in_range;
            out_status_reg <= in_range ? STAT_QUERY_OK : STAT_RANGE_ERR;
        end
        else if (cmd.load_build)
        begin
            out_ok_reg     <= 1'b0;
            out_status_reg <= STAT_BUILD_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            built_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.commit_built)
            begin
                built_reg <= lim_ext + COUNT_W'(1);
            end
            if (cmd.load_query || cmd.load_build)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.build_skip = {1'b0, eff_lim} < built_reg;
    assign sts.init_last  = i_reg == lim_ext;
    assign sts.prime_go   = (sq_reg <= lim_ext + COUNT_W'(1)) &&
                            (COUNT_W'(p_reg) <= lim_ext);
    assign sts.prime_hit  = rdata_reg == FACTOR_W'(p_reg);
    assign sts.mult_go    = i_reg <= lim_ext;
    assign sts.v_gt_p     = v_reg > FACTOR_W'(p_reg);
    assign sts.div_last   = div_cnt_reg == '1;
    assign sts.div_exact  = rem_reg == '0;

    assign out_valid = out_valid_reg;
    assign factor    = out_ok_reg ? rdata_reg : '0;
    assign status    = out_status_reg;

endmodule

@@ hdl/greatest_prime_factor_sieve_top.sv @@
// ----------------------------------------------------------------------------
// greatest_prime_factor_sieve_top
// Greatest prime factor table: build by sieve, then answer single-entry queries.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input channel (in_valid/in_ready, command, index): one transaction is a
//    build (command 0) or a query (command 1). Output channel (out_valid/
//    out_ready, factor, status) returns exactly one transaction per input.
//  - cfg_wr_en/cfg_wr_data write table_limit; only while the block is idle.
//  - Query: result in the cycle after acceptance (registered table read); a
//    new query is taken every cycle while the receiver keeps up, so the rate
//    is one query per clock.
//  - Build: seed each entry with its index, then per prime p up to
//    sqrt(limit + 1) a walk over its multiples, stripping p from each one by
//    exact division while the entry stays above p, in the shared bit-serial
//    divider. A build whose limit lies below the size already built answers
//    at once.
//  - Receiver stall: the result register holds and in_ready stays low until
//    the pending transaction is taken.
//  - Reset: limit and built size clear to zero, so every query reports out of
//    range until the first build. No clearing pass over the table is needed.
// ----------------------------------------------------------------------------
module greatest_prime_factor_sieve_top
    import gpfs_pkg::*;
#(
    parameter int TABLE_DEPTH = GPFS_TABLE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [LIMIT_W-1:0]  index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FACTOR_W-1:0] factor,
    output logic [STATUS_W-1:0] status
);

    gpfs_cmd_t cmd;
    gpfs_sts_t sts;

    // Sequencer: owns the input handshake and every step of the build
    gpfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: table memory, counters, divider and the result register
    gpfs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .index       (index),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .factor      (factor),
        .status      (status)
    );

endmodule

@@ hdl/gpfs_checker.sv @@
// ----------------------------------------------------------------------------
// gpfs_checker
// Port-level checks on results and back-pressure, bound to the top level.
// ----------------------------------------------------------------------------
module gpfs_checker
    import gpfs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [FACTOR_W-1:0] factor,
    input logic [STATUS_W-1:0] status
);

    // Build and range results carry no factor
    a_no_factor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_BUILD_DONE || status == STAT_RANGE_ERR)
        |-> factor == '0)
        else $error("factor non-zero on build or range result");

    // Only the three defined status codes ever appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_QUERY_OK || status == STAT_RANGE_ERR ||
                       status == STAT_BUILD_DONE))
        else $error("undefined status code");

    // A stalled result blocks new transactions
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(factor) && $stable(status))
        else $error("stalled result changed");

    // An offered input transaction stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped before acceptance");

endmodule

bind greatest_prime_factor_sieve_top gpfs_checker u_gpfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .factor    (factor),
    .status    (status)
);

@@ sim/greatest_prime_factor_sieve_top_test.sv @@
// ----------------------------------------------------------------------------
// greatest_prime_factor_sieve_top_test
// Self-checking bench for the greatest prime factor sieve table: builds at
// growing limits, no-op builds below the built size, a full 64K-entry build
// and queries in and out of range, checked against a local sieve shadow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greatest_prime_factor_sieve_top_test;

    import gpfs_pkg::*;

    // A full 64K build runs with no handshake at all, so the stall
    // watchdog has to sit well above its length.
    localparam int unsigned QUIET_LIMIT  = 40_000_000;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [STATUS_W-1:0] status;
    } gpf_answer_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [LIMIT_W-1:0]  index;
    logic                out_valid;
    logic                out_ready;
    logic [FACTOR_W-1:0] factor;
    logic [STATUS_W-1:0] status;

    // Shadow of the block: the factor table, the number of valid entries and
    // the limit register.
    logic [FACTOR_W-1:0] gpf_table [0:GPFS_TABLE_DEPTH-1];
    int unsigned         entries_valid = 0;
    logic [LIMIT_W-1:0]  limit_shadow  = '0;

    // Answers owed by the block, oldest first
    gpf_answer_t         expected_answers [$];

    bit                  no_gaps        = 1'b0;
    int unsigned         error_count    = 0;
    int unsigned         builds_sent    = 0;
    int unsigned         sieve_count    = 0;
    int unsigned         queries_sent   = 0;
    int unsigned         answers_seen   = 0;
    int unsigned         quiet_cycles   = 0;

    greatest_prime_factor_sieve_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .factor      (factor),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    // Sieve over 0..lim: seed each entry with its index, then for every prime
    // p with p*p <= lim+1 strip p out of each multiple while the entry stays
    // above p and p divides it.
    function automatic void sieve_fill(int unsigned lim);
        int unsigned v;
        for (int unsigned i = 0; i <= lim; i++)
            gpf_table[i] = FACTOR_W'(i);
        for (int unsigned p = 2; p * p <= lim + 1 && p <= lim; p++)
        begin
            if (gpf_table[p] == FACTOR_W'(p))
            begin
                for (int unsigned m = 2 * p; m <= lim; m += p)
                begin
                    v = gpf_table[m];
                    while (v > p && v % p == 0)
                        v = v / p;
                    gpf_table[m] = FACTOR_W'(v);
                end
            end
        end
        entries_valid = lim + 1;
        sieve_count++;
    endfunction

    // Answer owed for one accepted transaction; a build also moves the shadow.
    // The limit register is 16 bits against a 64K table, so it never needs
    // saturating here.
    function automatic gpf_answer_t predict_answer(logic cmd, logic [LIMIT_W-1:0] idx);
        gpf_answer_t ans;
        if (cmd == CMD_BUILD)
        begin
            // A limit below the built size leaves the table untouched
            if (int'(limit_shadow) >= int'(entries_valid))
                sieve_fill(limit_shadow);
            ans.factor = '0;
            ans.status = STAT_BUILD_DONE;
        end
        else if (idx < entries_valid)
        begin
            ans.factor = gpf_table[idx];
            ans.status = STAT_QUERY_OK;
        end
        else
        begin
            ans.factor = '0;
            ans.status = STAT_RANGE_ERR;
        end
        return ans;
    endfunction

    function automatic void log_failure(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    // Idle cycles before the next transaction on either side; zero throughout
    // a back-to-back stretch.
    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 14);
    endfunction

    // Query index: mostly inside the built part, some right on the boundary,
    // some anywhere in the 16-bit space.
    function automatic logic [LIMIT_W-1:0] pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (entries_valid == 0 || sel == 0)
            return LIMIT_W'($urandom);
        if (sel == 1)
        begin
            if (entries_valid > 16'hFFFF)
                return 16'hFFFF;
            return LIMIT_W'(entries_valid - $urandom_range(0, 1));
        end
        return LIMIT_W'($urandom_range(0, entries_valid - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Called at a rising edge. Presents one transaction after a random gap and
    // returns at the edge where it was taken, logging the answer owed.
    task automatic send_item(logic cmd, logic [LIMIT_W-1:0] idx);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        index    <= idx;
        // Inputs only move at rising edges, so the falling edge shows what
        // the next rising edge will see.
        do @(negedge clk); while (in_ready !== 1'b1);
        @(posedge clk);
        expected_answers.push_back(predict_answer(cmd, idx));
        if (cmd == CMD_BUILD)
            builds_sent++;
        else
            queries_sent++;
    endtask

    // The limit register is only written with the block idle: input quiet and
    // every owed answer returned (each transaction has exactly one answer).
    task automatic set_table_limit(logic [LIMIT_W-1:0] lim);
        in_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow  = lim;
    endtask

    // Result side: random stall with ready low, then ready high until one
    // transaction is taken, then check it against the oldest owed answer.
    initial
    begin : result_checker
        int unsigned stall;
        gpf_answer_t got;
        gpf_answer_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (out_valid !== 1'b1);
            got.factor = factor;
            got.status = status;
            @(posedge clk);
            answers_seen++;
            if (expected_answers.size() == 0)
            begin
                log_failure($sformatf("unexpected result: factor %0d status %0d",
                                      got.factor, got.status));
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.factor !== want.factor)
                    log_failure($sformatf("factor: expected %0d, got %0d",
                                          want.factor, got.factor));
                if (got.status !== want.status)
                    log_failure($sformatf("status: expected %0d, got %0d",
                                          want.status, got.status));
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either channel
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d answers owed",
                         quiet_cycles, expected_answers.size());
                $display("** greatest_prime_factor_sieve_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Nothing built yet: every query is out of range
    task automatic test_before_first_build();
        send_item(CMD_QUERY, 16'd0);
        send_item(CMD_QUERY, 16'd1);
        send_item(CMD_QUERY, 16'hFFFF);
    endtask

    // Limit 0 straight from reset, then 1 and 2; the index field of a build
    // carries junk since the block ignores it.
    task automatic test_small_limits();
        send_item(CMD_BUILD, 16'hA5A5);
        send_item(CMD_QUERY, 16'd0);
        send_item(CMD_QUERY, 16'd1);
        set_table_limit(16'd1);
        send_item(CMD_BUILD, 16'h5A5A);
        send_item(CMD_QUERY, 16'd1);
        set_table_limit(16'd2);
        send_item(CMD_BUILD, 16'hFFFF);
        send_item(CMD_QUERY, 16'd2);
        send_item(CMD_QUERY, 16'd3);
    endtask

    // Limits below the built size answer build done and change nothing
    task automatic test_limit_below_built();
        set_table_limit(16'd0);
        send_item(CMD_BUILD, 16'd0);
        send_item(CMD_QUERY, 16'd2);
        set_table_limit(16'd2);
        send_item(CMD_BUILD, 16'd7);
        send_item(CMD_QUERY, 16'd3);
    endtask

    // Known values: a prime, a power of two, a prime square, a product of two
    // primes, the edge of the table and just past it, and the two seeds.
    task automatic test_sieve_values();
        logic [LIMIT_W-1:0] picks [8] = '{16'd97, 16'd64, 16'd49, 16'd119,
                                          16'd120, 16'd121, 16'd0, 16'd1};
        set_table_limit(16'd120);
        send_item(CMD_BUILD, 16'd0);
        foreach (picks[i])
            send_item(CMD_QUERY, picks[i]);
    endtask

    // Phases with growing limits (the built size never shrinks, so a lower
    // limit would only ever give a no-op build). Now and then a phase writes
    // a limit below the built size; stray builds inside a phase are no-ops.
    task automatic test_random_phases();
        int unsigned next_limit;
        for (int ph = 0; ph < 11; ph++)
        begin
            if ($urandom_range(0, 4) == 0)
                next_limit = $urandom_range(0, entries_valid - 1);
            else
                next_limit = entries_valid - 1 + $urandom_range(0, 90);
            set_table_limit(LIMIT_W'(next_limit));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_item(CMD_BUILD, LIMIT_W'($urandom));
            for (int n = 0; n < 40; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(CMD_BUILD, LIMIT_W'($urandom));
                else
                    send_item(CMD_QUERY, pick_index());
            end
        end
        no_gaps = 1'b0;
    endtask

    // Top limit: the whole 64K table, with factors above the sieving primes
    // (65535 = 3*5*17*257), the largest 16-bit prime and a no-op rebuild.
    task automatic test_full_table();
        logic [LIMIT_W-1:0] picks [6] = '{16'hFFFF, 16'hFFFE, 16'd65521,
                                          16'd32768, 16'd65025, 16'd0};
        set_table_limit(16'hFFFF);
        send_item(CMD_BUILD, 16'd0);
        foreach (picks[i])
            send_item(CMD_QUERY, picks[i]);
        for (int n = 0; n < 45; n++)
            send_item(CMD_QUERY, LIMIT_W'($urandom));
        send_item(CMD_BUILD, LIMIT_W'($urandom));
        send_item(CMD_QUERY, 16'hFFFF);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_QUERY;
        index       <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_first_build();
        test_small_limits();
        test_limit_below_built();
        test_sieve_values();
        test_random_phases();
        test_full_table();

        in_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        // Idle tail so that a stray extra result would still be caught
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d builds (%0d sieve passes, top size %0d) and %0d queries",
                 builds_sent, sieve_count, entries_valid, queries_sent);
        $display("%0d results checked, %0d errors", answers_seen, error_count);
        if (error_count == 0)
            $display("** greatest_prime_factor_sieve_top: PASSED **");
        else
            $display("** greatest_prime_factor_sieve_top: FAILED **");
        $finish;
    end

endmodule
